// ===== rtl/sctc_pkg.sv =====
// ----------------------------------------------------------------------------
// sctc_pkg
// Types, codes and the control classifier shared by the sorted control table.
// ----------------------------------------------------------------------------
package sctc_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int CNT_W           = 7;
	localparam int IDX_W           = 6;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	// commands
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// result status
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_CLEARED   = 3'd5;

	// control classes
	localparam logic [1:0] CLS_GARBAGE   = 2'd0;
	localparam logic [1:0] CLS_TWO_STATE = 2'd1;
	localparam logic [1:0] CLS_ONE_WAY   = 2'd2;
	localparam logic [1:0] CLS_TWO_WAY   = 2'd3;

	localparam logic [31:0]        USAGE_HAT      = 32'h0001_0039;
	localparam logic signed [31:0] HAT_LIMIT      = 32'sd15;
	localparam logic signed [31:0] TWO_STATE_HIGH = 32'sd2;

	// usability rule thresholds
	localparam logic [CNT_W-1:0] USE_TWO_WAY_MIN  = 7'd2;
	localparam logic [CNT_W:0]   USE_BUTTON_MIN   = 8'd3;
	localparam logic [CNT_W:0]   USE_BUTTON_ALONE = 8'd7;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] button_id;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic signed [31:0] rest_value;
		logic [31:0]        usage_code;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [1:0]         button_class;
		logic [IDX_W-1:0]   entry_index;
		logic signed [31:0] found_low;
		logic signed [31:0] found_high;
		logic signed [31:0] found_value;
		logic [31:0]        found_usage;
		logic               usable;
		logic [CNT_W-1:0]   two_state_count;
		logic [CNT_W-1:0]   one_way_count;
		logic [CNT_W-1:0]   two_way_count;
		logic [CNT_W-1:0]   garbage_count;
	} rsp_t;

	// one table row
	typedef struct packed {
		logic signed [31:0] id;
		logic signed [31:0] low;
		logic signed [31:0] high;
		logic signed [31:0] rest;
		logic [31:0]        usage;
	} entry_t;

	function automatic logic [1:0] classify(entry_t e);
		logic [1:0] c;
		if (e.high <= e.low)
			c = CLS_GARBAGE;
		else if (e.low == 32'sd0 && e.high <= TWO_STATE_HIGH)
			c = CLS_TWO_STATE;
		else if (e.low == 32'sd0 && e.high < HAT_LIMIT && e.usage == USAGE_HAT)
			c = CLS_GARBAGE;
		else if (e.low == 32'sd0 && e.rest == 32'sd0)
			c = CLS_ONE_WAY;
		else if (e.low < e.rest && e.high > e.rest)
			c = CLS_TWO_WAY;
		else
			c = CLS_GARBAGE;
		return c;
	endfunction

endpackage

// ===== rtl/sctc_if.sv =====
// ----------------------------------------------------------------------------
// sctc_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface sctc_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sorted_control_table_classifier_core.sv =====
// ----------------------------------------------------------------------------
// sorted_control_table_classifier_core
// Sorted control descriptor table with binary search, ordered insert and
// per-class counters.
// ----------------------------------------------------------------------------
// One command item in, one result item out (cmd 3 is taken and dropped). The
// table is a single-port-read, single-port-write memory of TABLE_DEPTH rows;
// every search probe and every row move goes through that memory, so a lookup
// makes one probe read per search step, and an insert first moves each row at
// or above the insert position up by one, then writes the new row in its place.
// The block takes no new item while one is in work. A finished result sits in
// an output register, so a new item may be taken while it waits. No clearing
// pass is needed after reset: rows at or above the entry count are never read.
// ----------------------------------------------------------------------------
module sorted_control_table_classifier_core #(
	parameter int TABLE_DEPTH = sctc_pkg::DEF_TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	sctc_if.sink          req,
	sctc_if.source        rsp
);
	import sctc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// sequencer states
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SRCH = 7'b0000010,  // issue probe read of mid row
		S_CMP  = 7'b0000100,  // compare key against probed id
		S_SHRD = 7'b0001000,  // first read of the row move
		S_SHWR = 7'b0010000,  // move row up by one, read the next one down
		S_WRT  = 7'b0100000,  // write the new row, bump its class counter
		S_RESP = 7'b1000000   // hand the result to the output register
	} state_t;

	state_t state_q;

	entry_t       mem [TABLE_DEPTH];
	entry_t       rdata_q;
	logic         mem_re;
	logic         mem_we;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	entry_t       wdata;

	entry_t       item_q;       // descriptor of the item in work
	logic [1:0]   cmd_q;
	logic [CW-1:0] lo_q, hi_q;  // search window
	logic [AW-1:0] mid_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] idx_q;       // row being moved
	logic [2:0]   status_q;
	logic         show_q;       // result carries an entry
	logic         from_item_q;  // entry comes from the item, not the table

	logic [CW-1:0]    entry_count_q;
	logic [CNT_W-1:0] two_state_q, one_way_q, two_way_q, garbage_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	// search arithmetic
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid_full;
	logic [AW-1:0] mid;
	logic [CW-1:0] cnt_m1;
	logic          key_lt, key_gt;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_full = mid_sum[CW:1];
	assign mid      = mid_full[AW-1:0];
	assign cnt_m1   = entry_count_q - CW'(1);
	assign key_lt   = item_q.id < rdata_q.id;
	assign key_gt   = item_q.id > rdata_q.id;

	// result assembly
	entry_t           res_ent;
	logic [1:0]       res_cls;
	logic [AW+IDX_W-1:0] pos_ext;
	logic [CNT_W:0]   buttons;
	logic             usable;
	logic             rsp_load;

	assign res_ent  = from_item_q ? item_q : rdata_q;
	assign res_cls  = classify(res_ent);
	assign pos_ext  = {{IDX_W{1'b0}}, pos_q};
	assign buttons  = {1'b0, one_way_q} + {1'b0, two_state_q};
	assign usable   = (two_way_q >= USE_TWO_WAY_MIN && buttons >= USE_BUTTON_MIN) ||
	                  (buttons >= USE_BUTTON_ALONE);
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_we = 1'b0;
		raddr  = mid;
		waddr  = pos_q;
		wdata  = item_q;
		case (state_q)
			S_SRCH: begin
				mem_re = (lo_q < hi_q);
				raddr  = mid;
			end
			S_SHRD: begin
				mem_re = 1'b1;
				raddr  = idx_q;
			end
			S_SHWR: begin
				mem_we = 1'b1;
				waddr  = idx_q + AW'(1);
				wdata  = rdata_q;
				mem_re = (idx_q != pos_q);
				raddr  = idx_q - AW'(1);
			end
			S_WRT: begin
				mem_we = 1'b1;
				waddr  = pos_q;
				wdata  = item_q;
			end
			default: begin
				mem_re = 1'b0;
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	// sequencer, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			two_state_q   <= '0;
			one_way_q     <= '0;
			two_way_q     <= '0;
			garbage_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.data.cmd == CMD_CLEAR) begin
							entry_count_q <= '0;
							two_state_q   <= '0;
							one_way_q     <= '0;
							two_way_q     <= '0;
							garbage_q     <= '0;
							state_q       <= S_RESP;
						end else if (req.data.cmd == CMD_ADD ||
						             req.data.cmd == CMD_LOOKUP) begin
							state_q <= S_SRCH;
						end
						// unused command: dropped, no result
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q)
						state_q <= S_CMP;
					else if (cmd_q != CMD_ADD || entry_count_q >= CW'(TABLE_DEPTH))
						state_q <= S_RESP;
					else if (entry_count_q == lo_q)
						state_q <= S_WRT;
					else
						state_q <= S_SHRD;
				end
				S_CMP: begin
					if (key_lt || key_gt)
						state_q <= S_SRCH;
					else
						state_q <= S_RESP;
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (idx_q == pos_q)
						state_q <= S_WRT;
				end
				S_WRT: begin
					entry_count_q <= entry_count_q + CW'(1);
					case (classify(item_q))
						CLS_TWO_STATE: if (two_state_q != CNT_MAX) two_state_q <= two_state_q + 7'd1;
						CLS_ONE_WAY:   if (one_way_q != CNT_MAX) one_way_q <= one_way_q + 7'd1;
						CLS_TWO_WAY:   if (two_way_q != CNT_MAX) two_way_q <= two_way_q + 7'd1;
						default:       if (garbage_q != CNT_MAX) garbage_q <= garbage_q + 7'd1;
					endcase
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q        <= req.data.cmd;
				item_q.id    <= req.data.button_id;
				item_q.low   <= req.data.range_low;
				item_q.high  <= req.data.range_high;
				item_q.rest  <= req.data.rest_value;
				item_q.usage <= req.data.usage_code;
				lo_q         <= '0;
				hi_q         <= entry_count_q;
				status_q     <= ST_CLEARED;
				show_q       <= 1'b0;
				from_item_q  <= 1'b0;
			end
			S_SRCH: begin
				mid_q <= mid;
				if (!(lo_q < hi_q)) begin
					pos_q <= lo_q[AW-1:0];
					idx_q <= cnt_m1[AW-1:0];
					if (cmd_q != CMD_ADD) begin
						status_q <= ST_NOT_FOUND;
						show_q   <= 1'b0;
					end else if (entry_count_q >= CW'(TABLE_DEPTH)) begin
						status_q <= ST_FULL;
						show_q   <= 1'b0;
					end
				end
			end
			S_CMP: begin
				if (key_lt)
					hi_q <= CW'(mid_q);
				else if (key_gt)
					lo_q <= CW'(mid_q) + CW'(1);
				else begin
					pos_q    <= mid_q;
					status_q <= (cmd_q == CMD_ADD) ? ST_DUPLICATE : ST_FOUND;
					show_q   <= 1'b1;
				end
			end
			S_SHWR: begin
				if (idx_q != pos_q)
					idx_q <= idx_q - AW'(1);
			end
			S_WRT: begin
				status_q    <= ST_INSERTED;
				show_q      <= 1'b1;
				from_item_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status          <= status_q;
			rsp_q.button_class    <= show_q ? res_cls : CLS_GARBAGE;
			rsp_q.entry_index     <= show_q ? pos_ext[IDX_W-1:0] : '0;
			rsp_q.found_low       <= show_q ? res_ent.low : '0;
			rsp_q.found_high      <= show_q ? res_ent.high : '0;
			rsp_q.found_value     <= show_q ? res_ent.rest : '0;
			rsp_q.found_usage     <= show_q ? res_ent.usage : '0;
			rsp_q.usable          <= usable;
			rsp_q.two_state_count <= two_state_q;
			rsp_q.one_way_count   <= one_way_q;
			rsp_q.two_way_count   <= two_way_q;
			rsp_q.garbage_count   <= garbage_q;
		end
	end

endmodule
